FILE: rtl/pidc_pkg.sv
// pidc_pkg: shared types and constants for the pid controller step block
// covers widths, register indexes, state encoding and controller/datapath structs
// no dependencies
package pidc_pkg;

	// fixed constants of the control law
	localparam logic [15:0] DT_LIMIT_US       = 16'd1500;
	localparam logic [15:0] FILTER_BETA_RESET = 16'd6554;

	// configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// shared multiplier and divider widths
	localparam int MUL_A_W     = 34;
	localparam int MUL_B_W     = 21;
	localparam int PROD_W      = MUL_A_W + MUL_B_W;
	localparam int DIV_NUM_W   = PROD_W - 1;
	localparam int DIV_DEN_W   = 20;
	localparam int DIV_STEPS   = DIV_NUM_W / 2;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	// microseconds per second, as divisor and as negated scale factor
	localparam logic [DIV_DEN_W-1:0]      USEC_DEN         = 20'd1000000;
	localparam logic signed [MUL_B_W-1:0] NEG_USEC_PER_SEC = -21'sd1000000;

	// register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_INTEG_GAIN  = 3'd1,
		REG_DERIV_GAIN  = 3'd2,
		REG_INTEG_LIMIT = 3'd3,
		REG_OUT_MIN     = 3'd4,
		REG_OUT_MAX     = 3'd5,
		REG_FILTER_ON   = 3'd6,
		REG_FILTER_BETA = 3'd7
	} cfg_reg_t;

	// controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_P,
		S_LD_P,
		S_MUL_DG,
		S_MUL_DS,
		S_DIV_D,
		S_WAIT_D,
		S_FILT_A,
		S_FILT_B,
		S_FILT_C,
		S_MUL_IG,
		S_MUL_IDT,
		S_DIV_I,
		S_WAIT_I,
		S_TOTAL
	} ctrl_state_t;

	// operand pairs of the shared multiplier
	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_PROP,
		MUL_DGAIN,
		MUL_DSCALE,
		MUL_FOLD,
		MUL_FNEW,
		MUL_IGAIN,
		MUL_IDT
	} mul_op_t;

	typedef enum logic {
		DIV_DERIV,
		DIV_INTEG
	} div_sel_t;

	// controller to datapath
	typedef struct packed {
		logic     take;
		mul_op_t  mul_op;
		logic     ld_p;
		logic     div_start;
		div_sel_t div_sel;
		logic     ld_deriv;
		logic     ld_facc;
		logic     ld_filt;
		logic     ld_integ;
		logic     finish;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic en;
		logic dt_ok;
		logic filt_on;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

FILE: rtl/pidc_div.sv
// pidc_div: iterative signed-by-unsigned divider, two quotient bits per cycle
// quotient truncated toward zero; depends on pidc_pkg
module pidc_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [pidc_pkg::PROD_W-1:0]    dividend,
	input  logic [pidc_pkg::DIV_DEN_W-1:0]        divisor,
	output logic                                  done,
	output logic signed [pidc_pkg::PROD_W-1:0]    quotient
);
	import pidc_pkg::*;

	logic                     run_q;
	logic                     fin_q;
	logic                     done_q;
	logic [DIV_CNT_W-1:0]     cnt_q;
	logic                     neg_q;
	logic [DIV_NUM_W-1:0]     num_q;
	logic [DIV_DEN_W-1:0]     rem_q;
	logic [DIV_DEN_W-1:0]     den_q;
	logic signed [PROD_W-1:0] quot_q;

	logic [PROD_W-1:0]        dividend_mag;
	logic [DIV_DEN_W:0]       r1;
	logic [DIV_DEN_W:0]       r1n;
	logic [DIV_DEN_W:0]       r2;
	logic [DIV_DEN_W:0]       r2n;
	logic                     q1;
	logic                     q2;

	// magnitude of the dividend
	assign dividend_mag = dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);

	// two restoring steps
	always_comb begin
		r1  = {rem_q, num_q[DIV_NUM_W-1]};
		q1  = (r1 >= {1'b0, den_q});
		r1n = q1 ? (r1 - {1'b0, den_q}) : r1;
		r2  = {r1n[DIV_DEN_W-1:0], num_q[DIV_NUM_W-2]};
		q2  = (r2 >= {1'b0, den_q});
		r2n = q2 ? (r2 - {1'b0, den_q}) : r2;
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= run_q && !start && (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					run_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// shift registers and sign fix
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend_mag[DIV_NUM_W-1:0];
			rem_q <= '0;
			den_q <= divisor;
			neg_q <= dividend[PROD_W-1];
		end else if (run_q) begin
			num_q <= {num_q[DIV_NUM_W-3:0], q1, q2};
			rem_q <= r2n[DIV_DEN_W-1:0];
		end
		if (fin_q) begin
			quot_q <= neg_q ? -signed'({1'b0, num_q}) : signed'({1'b0, num_q});
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

FILE: rtl/pidc_datapath.sv
// pidc_datapath: configuration registers, controller state, shared multiplier,
// divider instance and output register; depends on pidc_pkg and pidc_div
module pidc_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pidc_pkg::dp_cmd_t                 cmd,
	output pidc_pkg::dp_status_t              status,
	input  logic                              cfg_we,
	input  logic [pidc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [pidc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic signed [15:0]                setpoint,
	input  logic signed [15:0]                measurement,
	input  logic [15:0]                       elapsed_us,
	input  logic                              loop_enable,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [15:0]                drive
);
	import pidc_pkg::*;

	// saturate a product or quotient to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
		logic signed [31:0] r;
		if (x > PROD_W'(signed'(32'h7fffffff)))
			r = 32'sh7fffffff;
		else if (x < PROD_W'(signed'(32'h80000000)))
			r = signed'(32'h80000000);
		else
			r = x[31:0];
		return r;
	endfunction

	// configuration
	logic [15:0]        prop_gain_q;
	logic [15:0]        integ_gain_q;
	logic [15:0]        deriv_gain_q;
	logic [14:0]        integ_limit_q;
	logic signed [15:0] out_min_q;
	logic signed [15:0] out_max_q;
	logic               filt_on_q;
	logic [15:0]        beta_q;

	// controller state
	logic signed [31:0] integ_q;
	logic signed [15:0] prev_q;
	logic signed [31:0] deriv_q;
	logic signed [31:0] filt_q;

	// per-transaction registers
	logic signed [16:0] err_q;
	logic signed [16:0] dm_q;
	logic signed [15:0] meas_q;
	logic [15:0]        dt_q;
	logic               dt_ok_q;
	logic               en_q;
	logic signed [31:0] p_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] facc_q;

	// output register
	logic               out_valid_q;
	logic signed [15:0] drive_q;

	// combinational
	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]   mul_prod;
	logic [16:0]                one_minus_beta;
	logic                       div_done;
	logic signed [PROD_W-1:0]   div_quot;
	logic [DIV_DEN_W-1:0]       div_den;
	logic signed [PROD_W:0]     mix;
	logic signed [31:0]         filt_new;
	logic signed [33:0]         integ_acc;
	logic signed [33:0]         integ_lim;
	logic signed [31:0]         integ_new;
	logic signed [33:0]         sum;
	logic signed [25:0]         total;
	logic signed [15:0]         drive_new;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= '0;
			integ_gain_q  <= '0;
			deriv_gain_q  <= '0;
			integ_limit_q <= '0;
			out_min_q     <= '0;
			out_max_q     <= '0;
			filt_on_q     <= 1'b0;
			beta_q        <= FILTER_BETA_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PROP_GAIN:   prop_gain_q   <= cfg_data;
				REG_INTEG_GAIN:  integ_gain_q  <= cfg_data;
				REG_DERIV_GAIN:  deriv_gain_q  <= cfg_data;
				REG_INTEG_LIMIT: integ_limit_q <= cfg_data[14:0];
				REG_OUT_MIN:     out_min_q     <= signed'(cfg_data);
				REG_OUT_MAX:     out_max_q     <= signed'(cfg_data);
				REG_FILTER_ON:   filt_on_q     <= cfg_data[0];
				REG_FILTER_BETA: beta_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// operand selection for the shared multiplier
	assign one_minus_beta = 17'h10000 - {1'b0, beta_q};

	always_comb begin
		case (cmd.mul_op)
			MUL_PROP: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = signed'(MUL_B_W'(prop_gain_q));
			end
			MUL_DGAIN: begin
				mul_a = MUL_A_W'(dm_q);
				mul_b = signed'(MUL_B_W'(deriv_gain_q));
			end
			MUL_DSCALE: begin
				mul_a = prod_q[MUL_A_W-1:0];
				mul_b = NEG_USEC_PER_SEC;
			end
			MUL_FOLD: begin
				mul_a = MUL_A_W'(filt_q);
				mul_b = signed'(MUL_B_W'(one_minus_beta));
			end
			MUL_FNEW: begin
				mul_a = MUL_A_W'(deriv_q);
				mul_b = signed'(MUL_B_W'(beta_q));
			end
			MUL_IGAIN: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = signed'(MUL_B_W'(integ_gain_q));
			end
			MUL_IDT: begin
				mul_a = prod_q[MUL_A_W-1:0];
				mul_b = signed'(MUL_B_W'(dt_q));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_prod = mul_a * mul_b;

	// divider, shared by the rate and the integral increment
	assign div_den = (cmd.div_sel == DIV_DERIV) ? DIV_DEN_W'(dt_q) : USEC_DEN;

	pidc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quot)
	);

	// derivative low-pass mix, floor divide by 2^16
	assign mix      = (PROD_W+1)'(facc_q) + (PROD_W+1)'(prod_q);
	assign filt_new = mix[47:16];

	// integral update with symmetric clamp, forced to zero while the integral gain is zero
	always_comb begin
		integ_acc = 34'(integ_q) + div_quot[33:0];
		integ_lim = signed'({11'd0, integ_limit_q, 8'd0});
		if (integ_acc < -integ_lim)
			integ_new = integ_acc[31:0] - integ_acc[31:0] - integ_lim[31:0];
		else if (integ_acc > integ_lim)
			integ_new = integ_lim[31:0];
		else
			integ_new = integ_acc[31:0];
		if (integ_gain_q == 16'd0)
			integ_new = '0;
	end

	// sum of terms, floor divide by 256, output clamp
	always_comb begin
		sum   = 34'(p_q) + 34'(integ_q) + 34'(deriv_q);
		total = sum[33:8];
		if (total < 26'(out_min_q))
			drive_new = out_min_q;
		else if (total > 26'(out_max_q))
			drive_new = out_max_q;
		else
			drive_new = total[15:0];
	end

	// transaction capture and working registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			err_q   <= 17'(setpoint) - 17'(measurement);
			dm_q    <= 17'(measurement) - 17'(prev_q);
			meas_q  <= measurement;
			dt_q    <= elapsed_us;
			dt_ok_q <= (elapsed_us != 16'd0) && (elapsed_us <= DT_LIMIT_US);
			en_q    <= loop_enable;
		end
		if (cmd.mul_op != MUL_NONE) begin
			prod_q <= mul_prod;
		end
		if (cmd.ld_p) begin
			p_q <= sat32(prod_q);
		end
		if (cmd.ld_facc) begin
			facc_q <= prod_q;
		end
		if (cmd.finish) begin
			drive_q <= en_q ? drive_new : 16'sd0;
		end
	end

	// controller state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			prev_q  <= '0;
			deriv_q <= '0;
			filt_q  <= '0;
		end else begin
			if (cmd.ld_deriv) begin
				deriv_q <= sat32(div_quot);
			end else if (cmd.ld_filt) begin
				deriv_q <= filt_new;
				filt_q  <= filt_new;
			end
			if (cmd.ld_integ) begin
				integ_q <= integ_new;
			end else if (cmd.finish && !en_q) begin
				integ_q <= '0;
			end
			if (cmd.finish && en_q) begin
				prev_q <= meas_q;
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.en       = en_q;
	assign status.dt_ok    = dt_ok_q;
	assign status.filt_on  = filt_on_q;
	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

endmodule

FILE: rtl/pidc_ctrl.sv
// pidc_ctrl: sequencing state machine for one controller step
// drives datapath commands from status; depends on pidc_pkg
module pidc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  pidc_pkg::dp_status_t  status,
	output pidc_pkg::dp_cmd_t     cmd
);
	import pidc_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        take;

	assign in_stall = (state_q != S_IDLE);
	assign take     = in_valid && (state_q == S_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_MUL_P;
				end
			end
			// enable bit is registered by now; a disabled step skips the arithmetic
			S_MUL_P:   state_d = status.en ? S_LD_P : S_TOTAL;
			S_LD_P: begin
				if (status.dt_ok)
					state_d = S_MUL_DG;
				else if (status.filt_on)
					state_d = S_FILT_A;
				else
					state_d = S_MUL_IG;
			end
			S_MUL_DG:  state_d = S_MUL_DS;
			S_MUL_DS:  state_d = S_DIV_D;
			S_DIV_D:   state_d = S_WAIT_D;
			S_WAIT_D: begin
				if (status.div_done)
					state_d = status.filt_on ? S_FILT_A : S_MUL_IG;
			end
			S_FILT_A:  state_d = S_FILT_B;
			S_FILT_B:  state_d = S_FILT_C;
			S_FILT_C:  state_d = S_MUL_IG;
			S_MUL_IG:  state_d = S_MUL_IDT;
			S_MUL_IDT: state_d = S_DIV_I;
			S_DIV_I:   state_d = S_WAIT_I;
			S_WAIT_I: begin
				if (status.div_done)
					state_d = S_TOTAL;
			end
			S_TOTAL: begin
				if (status.out_free)
					state_d = S_IDLE;
			end
			default:   state_d = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd           = '0;
		cmd.take      = take;
		cmd.mul_op    = MUL_NONE;
		cmd.div_sel   = DIV_DERIV;
		case (state_q)
			S_MUL_P:   cmd.mul_op = MUL_PROP;
			S_LD_P:    cmd.ld_p = 1'b1;
			S_MUL_DG:  cmd.mul_op = MUL_DGAIN;
			S_MUL_DS:  cmd.mul_op = MUL_DSCALE;
			S_DIV_D: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_DERIV;
			end
			S_WAIT_D:  cmd.ld_deriv = status.div_done;
			S_FILT_A:  cmd.mul_op = MUL_FOLD;
			S_FILT_B: begin
				cmd.ld_facc = 1'b1;
				cmd.mul_op  = MUL_FNEW;
			end
			S_FILT_C:  cmd.ld_filt = 1'b1;
			S_MUL_IG:  cmd.mul_op = MUL_IGAIN;
			S_MUL_IDT: cmd.mul_op = MUL_IDT;
			S_DIV_I: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_INTEG;
			end
			S_WAIT_I: begin
				cmd.div_sel  = DIV_INTEG;
				cmd.ld_integ = status.div_done;
			end
			S_TOTAL:   cmd.finish = status.out_free;
			default: ;
		endcase
	end

endmodule

FILE: rtl/pid_controller_step.sv
// pid_controller_step: top level of the fixed-point pid step block
// joins pidc_ctrl and pidc_datapath; depends on pidc_pkg
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------------
//  input   | in_valid/in_stall  | setpoint, measurement, elapsed_us, loop_enable
//  output  | out_valid/out_stall| drive
//  config  | cfg_we             | cfg_index, cfg_data
//
// one transaction at a time; a new input is taken only when the sequencer is idle
// enabled step with fresh rate: rate and integral divider passes, filter when on;
// each divider pass runs through start, 27 radix-4 iterations, sign fix and done
// enabled step with held rate: integral divider pass only, filter when on
// disabled step: skips the arithmetic and goes straight to the output
// output register lets the next input be taken while drive waits under out_stall;
// a step that finds the output register full and stalled waits in its last state
// reset clears configuration to defaults and all controller state to zero
module pid_controller_step (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [15:0]                setpoint,
	input  logic signed [15:0]                measurement,
	input  logic [15:0]                       elapsed_us,
	input  logic                              loop_enable,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [15:0]                drive,
	input  logic                              cfg_we,
	input  logic [pidc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [pidc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import pidc_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	pidc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	pidc_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.setpoint    (setpoint),
		.measurement (measurement),
		.elapsed_us  (elapsed_us),
		.loop_enable (loop_enable),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.drive       (drive)
	);

endmodule

FILE: verif/pid_controller_step_test.sv
// pid_controller_step_test: self-checking bench for the fixed-point pid step block
// predicts every drive value with its own q24.8 controller copy; needs pidc_pkg and the rtl
`timescale 1ns / 100ps

module pid_controller_step_test;
	import pidc_pkg::*;

	// receiver stall patterns
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HALF,
		STALL_HEAVY
	} stall_mode_t;

	// mirrors the controller registers and state, keeps the drive values still owed
	class drive_checker;
		logic [15:0]        prop_gain, integ_gain, deriv_gain, filter_beta;
		logic [14:0]        integ_limit;
		logic signed [15:0] out_min, out_max;
		logic               filter_on;
		int                 integ_acc, deriv_val, filt_val;
		logic signed [15:0] last_meas;
		logic signed [15:0] owed_drive[$];
		int                 errors;

		function new();
			prop_gain = '0;
			integ_gain = '0;
			deriv_gain = '0;
			integ_limit = '0;
			out_min = '0;
			out_max = '0;
			filter_on = 1'b0;
			filter_beta = FILTER_BETA_RESET;
			integ_acc = 0;
			deriv_val = 0;
			filt_val = 0;
			last_meas = '0;
			errors = 0;
		endfunction

		function longint clamp32(longint x);
			if (x > longint'(32'sh7FFFFFFF))
				return longint'(32'sh7FFFFFFF);
			if (x < longint'(32'sh80000000))
				return longint'(32'sh80000000);
			return x;
		endfunction

		function longint floor_div(longint x, longint d);
			longint q;
			q = x / d;
			if ((x % d) != 0 && x < 0)
				q = q - 1;
			return q;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [15:0] data);
			case (idx)
				REG_PROP_GAIN:   prop_gain = data;
				REG_INTEG_GAIN:  integ_gain = data;
				REG_DERIV_GAIN:  deriv_gain = data;
				REG_INTEG_LIMIT: integ_limit = data[14:0];
				REG_OUT_MIN:     out_min = data;
				REG_OUT_MAX:     out_max = data;
				REG_FILTER_ON:   filter_on = data[0];
				REG_FILTER_BETA: filter_beta = data;
				default: ;
			endcase
		endfunction

		// one control step, pushes the drive it must produce
		function void note_step(logic signed [15:0] sp, logic signed [15:0] meas,
				logic [15:0] dt, logic en);
			longint err, prop_term, mix, acc, lim, total;
			if (!en) begin
				integ_acc = 0;
				owed_drive.push_back(16'sd0);
				return;
			end
			err = longint'(sp) - longint'(meas);
			prop_term = clamp32(longint'(prop_gain) * err);

			// rate term on measurement, only for a usable time step
			if (dt != 0 && dt <= DT_LIMIT_US)
				deriv_val = int'(clamp32(-(longint'(deriv_gain) *
					(longint'(meas) - longint'(last_meas))) * 1000000 / longint'(dt)));

			// low-pass runs on every enabled step, also on a held rate
			if (filter_on) begin
				mix = longint'(filt_val) * (65536 - longint'(filter_beta)) +
					longint'(filter_beta) * longint'(deriv_val);
				filt_val = int'(floor_div(mix, 65536));
				deriv_val = filt_val;
			end
			last_meas = meas;

			// integral with symmetric clamp
			acc = longint'(integ_acc) + (longint'(integ_gain) * err * longint'(dt)) / 1000000;
			lim = longint'(integ_limit) * 256;
			if (acc < -lim)
				acc = -lim;
			else if (acc > lim)
				acc = lim;
			if (integ_gain == 0)
				acc = 0;
			integ_acc = int'(acc);

			// sum and saturate, minimum test first
			total = floor_div(prop_term + longint'(integ_acc) + longint'(deriv_val), 256);
			if (total < longint'(out_min))
				total = longint'(out_min);
			else if (total > longint'(out_max))
				total = longint'(out_max);
			owed_drive.push_back(total[15:0]);
		endfunction

		function void check_drive(logic signed [15:0] got);
			logic signed [15:0] want;
			if (owed_drive.size() == 0) begin
				$display("%0t: drive %0d arrived with no transaction waiting", $time, got);
				errors++;
				return;
			end
			want = owed_drive.pop_front();
			if (got !== want) begin
				$display("%0t: drive mismatch, expected %0d, actual %0d", $time, want, got);
				errors++;
			end
		endfunction

		function int pending();
			return owed_drive.size();
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic signed [15:0]        setpoint;
	logic signed [15:0]        measurement;
	logic [15:0]               elapsed_us;
	logic                      loop_enable;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [15:0]        drive;
	logic                      cfg_we;
	logic [CFG_INDEX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;

	drive_checker drive_chk = new();
	stall_mode_t  stall_mode = STALL_NONE;
	int           stall_left = 0;

	pid_controller_step u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.setpoint    (setpoint),
		.measurement (measurement),
		.elapsed_us  (elapsed_us),
		.loop_enable (loop_enable),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.drive       (drive),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver stall, a new random pattern is chosen whenever the current run ends
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(50, 400);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HALF:  out_stall <= 1'($urandom_range(0, 1));
			default:     out_stall <= ($urandom_range(0, 15) != 0);
		endcase
	end

	// register writes, accepted inputs and delivered drives
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				drive_chk.set_reg(cfg_reg_t'(cfg_index), cfg_data);
			if (in_valid && !in_stall)
				drive_chk.note_step(setpoint, measurement, elapsed_us, loop_enable);
			if (out_valid === 1'b1 && !out_stall)
				drive_chk.check_drive(drive);
		end
	end

	task automatic put_reg(input cfg_reg_t idx, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic load_config(input logic [15:0] pg, ig, dg, il, lo, hi, fo, fb);
		put_reg(REG_PROP_GAIN, pg);
		put_reg(REG_INTEG_GAIN, ig);
		put_reg(REG_DERIV_GAIN, dg);
		put_reg(REG_INTEG_LIMIT, il);
		put_reg(REG_OUT_MIN, lo);
		put_reg(REG_OUT_MAX, hi);
		put_reg(REG_FILTER_ON, fo);
		put_reg(REG_FILTER_BETA, fb);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// holds one transaction until the block takes it; valid stays high afterwards
	task automatic send_step(input logic signed [15:0] sp, input logic signed [15:0] meas,
			input logic [15:0] dt, input logic en);
		in_valid <= 1'b1;
		setpoint <= sp;
		measurement <= meas;
		elapsed_us <= dt;
		loop_enable <= en;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic idle_for(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// stop sending until every owed drive has come back; the accepting edge passes
	// first so the last accepted transaction is already counted
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (drive_chk.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_random_phase(input int phase, input int count);
		logic [15:0]        pg, ig, dg, il, lo, hi, fo, fb, dt;
		logic signed [15:0] sp, meas, sp_track, meas_track;
		logic               en;
		int                 burst_left;
		burst_left = 0;
		sp_track = '0;
		meas_track = '0;

		// mostly moderate gains so the output is not pinned at a rail
		pg = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1024));
		ig = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4096));
		dg = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 256));
		il = 16'($urandom);
		lo = -16'($urandom_range(0, 32767));
		hi = 16'($urandom_range(0, 32767));
		fo = 16'($urandom);
		fb = 16'($urandom);
		case (phase)
			0: begin
				pg = 16'hFFFF; ig = 16'hFFFF; dg = 16'hFFFF; il = 16'h7FFF;
				lo = 16'h8000; hi = 16'h7FFF; fo = 16'h0001; fb = 16'hFFFF;
			end
			1: begin
				pg = '0; ig = '0; dg = '0; il = '0;
				lo = 16'h0123; hi = 16'h0123; fo = 16'h0001; fb = '0;
			end
			2: begin
				lo = 16'd1000; hi = -16'sd1000; fo = 16'h0001; fb = '0;
			end
			3: ig = '0;
			default: ;
		endcase
		drain_results();
		load_config(pg, ig, dg, il, lo, hi, fo, fb);

		for (int i = 0; i < count; i++) begin
			// operating point: slow walk, full-range noise or rail values
			case ($urandom_range(0, 9))
				0: begin
					sp = 16'($urandom);
					meas = 16'($urandom);
				end
				1: begin
					sp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
					meas = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
				end
				default: begin
					if ($urandom_range(0, 15) == 0)
						sp_track = 16'($urandom);
					meas_track = meas_track + 16'($urandom_range(0, 512)) - 16'sd256;
					sp = sp_track;
					meas = meas_track;
				end
			endcase
			case ($urandom_range(0, 19))
				0: dt = '0;
				1: dt = 16'($urandom_range(32'd1501, 32'd65535));
				2: dt = DT_LIMIT_US;
				3: dt = 16'd1;
				default: dt = 16'($urandom_range(1, 1500));
			endcase
			en = ($urandom_range(0, 19) != 0);
			send_step(sp, meas, dt, en);

			// bursts with gaps that land anywhere in the step
			if (burst_left == 0) begin
				burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(20, 60)
					: $urandom_range(1, 8);
				idle_for($urandom_range(1, 90));
			end else begin
				burst_left--;
			end
			if ($urandom_range(0, 99) == 0)
				drain_results();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		setpoint <= '0;
		measurement <= '0;
		elapsed_us <= '0;
		loop_enable <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_PROP_GAIN;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unity p, moderate i and d, no filter, full output range
		load_config(16'h0100, 16'h4000, 16'h0040, 16'h2000, 16'h8000, 16'h7FFF,
			16'h0000, FILTER_BETA_RESET);
		send_step(16'sh0100, 16'sh0080, 16'd1000, 1'b1);
		send_step(16'sh7FFF, 16'sh8000, DT_LIMIT_US, 1'b1);
		send_step(16'sh8000, 16'sh7FFF, 16'd1501, 1'b1);
		send_step(16'sh0000, 16'sh0000, 16'd0, 1'b1);
		send_step(16'sd100, 16'sd50, 16'hFFFF, 1'b1);
		send_step(16'sh7FFF, 16'sh8000, 16'hFFFF, 1'b0);
		send_step(16'sh0000, 16'sh7FFF, 16'd1, 1'b1);
		send_step(16'sh0000, 16'sh8000, 16'd1, 1'b1);
		send_step(-16'sd1, 16'sh0000, 16'd700, 1'b1);
		send_step(16'sh1234, 16'sh1200, 16'd1000, 1'b1);
		drain_results();

		// directed: rail gains, no integral, minimum above maximum, filter on
		load_config(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0100, 16'hFF00,
			16'h0001, 16'h8000);
		send_step(16'sh0000, 16'sh0000, 16'd1000, 1'b1);
		send_step(16'sh7FFF, 16'sh8000, 16'd1, 1'b1);
		send_step(16'sh8000, 16'sh7FFF, DT_LIMIT_US, 1'b1);
		send_step(16'sh0000, 16'sh0010, 16'd0, 1'b1);
		send_step(16'sd100, 16'sd100, 16'd1501, 1'b1);
		send_step(16'sh0000, 16'sh0000, 16'd1000, 1'b0);

		for (int phase = 0; phase < 10; phase++)
			run_random_phase(phase, 140);

		drain_results();
		repeat (200) @(posedge clk);
		if (drive_chk.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// hang guard
	initial begin
		#8_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
